[hdl/huffman_tree_decoder_macros.svh]
// Assertion shorthands used by the port checker.
`ifndef HUFFMAN_TREE_DECODER_MACROS_SVH
`define HUFFMAN_TREE_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define HTD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("huffman_tree_decoder assertion failed");

// Next-cycle implication, sampled on clk, off while in reset
`define HTD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("huffman_tree_decoder assertion failed");

`endif

[hdl/htd_pkg.sv]
package htd_pkg;

	localparam int IDX_W = 8;
	localparam int SYM_W = 7;
	localparam int BYTE_W = 8;
	localparam int BIT_CNT_W = 4;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [SYM_W-1:0] sym_t;

	localparam sym_t SYM_NUL = '0;

	// Item opcodes
	typedef enum logic [1:0] {
		OP_NODE_WRITE = 2'd0,
		OP_DECODE     = 2'd1,
		OP_RESTART    = 2'd2
	} op_t;

	// One tree node as seen by the walker
	typedef struct packed {
		logic leaf;
		idx_t left;
		idx_t right;
		sym_t sym;
	} node_t;

	// Node memory write request
	typedef struct packed {
		logic  en;
		idx_t  idx;
		node_t node;
	} node_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_NODE,
		ST_CHILD,
		ST_EMIT,
		ST_FLUSH
	} walk_state_t;

endpackage

[hdl/htd_node_mem.sv]
module htd_node_mem import htd_pkg::*; #(
	parameter int NODE_COUNT = 256,
	parameter int SYMBOL_BITS = 7
) (
	input  logic     clk,
	input  node_wr_t wr,
	input  idx_t     rd_idx,
	output node_t    rd_node
);

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int ENTRY_W = 1 + 2 * IDX_W + SYMBOL_BITS;
	localparam int SYM_LO = 0;
	localparam int RIGHT_LO = SYMBOL_BITS;
	localparam int LEFT_LO = SYMBOL_BITS + IDX_W;
	localparam int LEAF_POS = SYMBOL_BITS + 2 * IDX_W;

	logic [ENTRY_W-1:0] mem [NODE_COUNT];
	logic [ENTRY_W-1:0] rdata_s1;
	logic               rd_ok_s1;
	logic               wr_ok;
	logic               rd_ok;

	// Indexes past the end of the store: writes dropped, reads give a zero node
	assign wr_ok = (int'(wr.idx) < NODE_COUNT);
	assign rd_ok = (int'(rd_idx) < NODE_COUNT);

	always_ff @(posedge clk) begin
		if (wr.en && wr_ok) begin
			mem[AW'(wr.idx)] <= {wr.node.leaf, wr.node.left, wr.node.right,
				SYMBOL_BITS'(wr.node.sym)};
		end
		rdata_s1 <= mem[AW'(rd_idx)];
		rd_ok_s1 <= rd_ok;
	end

	// Unpack the registered entry
	always_comb begin
		rd_node = '0;
		if (rd_ok_s1) begin
			rd_node.leaf = rdata_s1[LEAF_POS];
			rd_node.left = rdata_s1[LEFT_LO +: IDX_W];
			rd_node.right = rdata_s1[RIGHT_LO +: IDX_W];
			rd_node.sym = SYM_W'(rdata_s1[SYM_LO +: SYMBOL_BITS]);
		end
	end

endmodule

[hdl/htd_walk_ctrl.sv]
module htd_walk_ctrl import htd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [1:0]          opcode,
	input  idx_t                node_index,
	input  logic                node_is_leaf,
	input  idx_t                left_child,
	input  idx_t                right_child,
	input  sym_t                leaf_symbol,
	input  logic [BYTE_W-1:0]   code_byte,
	input  idx_t                root_node,
	output idx_t                rd_idx,
	input  node_t               rd_node,
	output node_wr_t            wr,
	output logic                result_valid,
	input  logic                result_ready,
	output sym_t                symbol,
	output logic                end_of_message,
	output logic                last
);

	walk_state_t state_q, state_d;

	idx_t                 walk_q, walk_d;
	idx_t                 nxt_q, nxt_d;
	logic                 done_q, done_d;
	logic [BYTE_W-1:0]    shift_q, shift_d;
	logic [BIT_CNT_W-1:0] bits_q, bits_d;
	sym_t                 sym_q, sym_d;
	logic                 pend_vld_q, pend_vld_d;
	sym_t                 pend_sym_q, pend_sym_d;
	logic                 out_vld_q, out_vld_d;
	sym_t                 out_sym_q, out_sym_d;
	logic                 out_eom_q, out_eom_d;
	logic                 out_last_q, out_last_d;

	logic accept;
	logic slot_free;
	logic byte_end;
	logic step_bit;
	logic next_bit;

	assign item_ready = (state_q == ST_IDLE);
	assign accept = item_valid && item_ready;
	assign slot_free = !out_vld_q || result_ready;
	assign byte_end = (bits_q == BIT_CNT_W'(1));
	assign step_bit = shift_q[BYTE_W-1];
	assign next_bit = shift_q[BYTE_W-2];

	assign result_valid = out_vld_q;
	assign symbol = out_sym_q;
	assign end_of_message = out_eom_q;
	assign last = out_last_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_DECODE && !done_q) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_NODE;
			ST_NODE: state_d = rd_node.leaf ? ST_EMIT : ST_CHILD;
			ST_CHILD: begin
				if (rd_node.leaf) begin
					state_d = ST_EMIT;
				end else if (byte_end) begin
					state_d = pend_vld_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!pend_vld_q || slot_free) begin
					state_d = (sym_q == SYM_NUL || byte_end) ? ST_FLUSH : ST_NODE;
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath and memory control
	always_comb begin
		walk_d = walk_q;
		nxt_d = nxt_q;
		done_d = done_q;
		shift_d = shift_q;
		bits_d = bits_q;
		sym_d = sym_q;
		pend_vld_d = pend_vld_q;
		pend_sym_d = pend_sym_q;
		out_vld_d = out_vld_q && !result_ready;
		out_sym_d = out_sym_q;
		out_eom_d = out_eom_q;
		out_last_d = out_last_q;
		rd_idx = walk_q;
		wr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_NODE_WRITE: begin
							wr.en = 1'b1;
							wr.idx = node_index;
							wr.node.leaf = node_is_leaf;
							wr.node.left = left_child;
							wr.node.right = right_child;
							wr.node.sym = leaf_symbol;
						end
						OP_RESTART: begin
							walk_d = root_node;
							done_d = 1'b0;
						end
						OP_DECODE: begin
							shift_d = code_byte;
							bits_d = BIT_CNT_W'(BYTE_W);
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: rd_idx = walk_q;
			// Walk node in hand: a leaf emits, else fetch the child
			ST_NODE: begin
				if (rd_node.leaf) begin
					sym_d = rd_node.sym;
				end else begin
					nxt_d = step_bit ? rd_node.right : rd_node.left;
					rd_idx = nxt_d;
				end
			end
			// Child in hand: a leaf emits, else it becomes the walk node and
			// its own child for the next bit is fetched at once unless the byte ends
			ST_CHILD: begin
				if (rd_node.leaf) begin
					sym_d = rd_node.sym;
				end else begin
					walk_d = nxt_q;
					shift_d = {shift_q[BYTE_W-2:0], 1'b0};
					bits_d = bits_q - BIT_CNT_W'(1);
					if (!byte_end) begin
						nxt_d = next_bit ? rd_node.right : rd_node.left;
						rd_idx = nxt_d;
					end
				end
			end
			// The held symbol goes out once a newer one shows it is not last
			ST_EMIT: begin
				if (!pend_vld_q || slot_free) begin
					if (pend_vld_q) begin
						out_vld_d = 1'b1;
						out_sym_d = pend_sym_q;
						out_eom_d = (pend_sym_q == SYM_NUL);
						out_last_d = 1'b0;
					end
					pend_vld_d = 1'b1;
					pend_sym_d = sym_q;
					walk_d = root_node;
					shift_d = {shift_q[BYTE_W-2:0], 1'b0};
					bits_d = bits_q - BIT_CNT_W'(1);
					if (sym_q == SYM_NUL) begin
						done_d = 1'b1;
					end
					rd_idx = root_node;
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					out_vld_d = 1'b1;
					out_sym_d = pend_sym_q;
					out_eom_d = (pend_sym_q == SYM_NUL);
					out_last_d = 1'b1;
					pend_vld_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			walk_q <= '0;
			done_q <= 1'b0;
			bits_q <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			walk_q <= walk_d;
			done_q <= done_d;
			bits_q <= bits_d;
			pend_vld_q <= pend_vld_d;
			out_vld_q <= out_vld_d;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		nxt_q <= nxt_d;
		shift_q <= shift_d;
		sym_q <= sym_d;
		pend_sym_q <= pend_sym_d;
		out_sym_q <= out_sym_d;
		out_eom_q <= out_eom_d;
		out_last_q <= out_last_d;
	end

endmodule

[hdl/huffman_tree_decoder.sv]
// Huffman tree decoder. Node writes load the code tree into a node memory
// (one write port and one read port, registered read); decode items
// walk that tree one bit at a time, most significant bit first, and each
// decoded symbol is a result transfer, the final one of a byte flagged by
// last. A node write, a restart, an ignored item or a decode byte after the
// end of a message is done at acceptance, in the idle state. Any other decode
// byte first gets the walk node in hand (accept, fetch, node), then per bit
// steps on in the child state when it reaches an internal node, passes the
// child and emit states when it reaches a leaf child and the emit state when
// the walk node is itself a leaf, plus a flush state to hand off the last
// symbol when the byte has yielded one. The chain of dependent node memory
// reads sets the pace. A symbol waits while the output register is stalled,
// so result back-pressure adds its stall cycles. Further items are taken
// once the byte is done, while the last result may still wait at the output
// register. A decoded NUL ends the message: the rest of the byte is dropped
// and decode bytes yield nothing until a restart. root_node, written at any
// APB address with paddr[2] low, takes effect at the next return to the root.
module huffman_tree_decoder import htd_pkg::*; #(
	parameter int NODE_COUNT = 256,
	parameter int SYMBOL_BITS = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        node_index,
	input  logic              node_is_leaf,
	input  logic [7:0]        left_child,
	input  logic [7:0]        right_child,
	input  logic [6:0]        leaf_symbol,
	input  logic [7:0]        code_byte,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [6:0]        symbol,
	output logic              end_of_message,
	output logic              last
);

	localparam logic CFG_IDX_ROOT = 1'b0;

	idx_t     root_q;
	idx_t     rd_idx;
	node_t    rd_node;
	node_wr_t wr;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = 32'(root_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_ROOT) begin
			root_q <= pwdata[IDX_W-1:0];
		end
	end

	htd_node_mem #(
		.NODE_COUNT (NODE_COUNT),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_node_mem (
		.clk    (clk),
		.wr     (wr),
		.rd_idx (rd_idx),
		.rd_node(rd_node)
	);

	htd_walk_ctrl u_walk_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.opcode        (opcode),
		.node_index    (node_index),
		.node_is_leaf  (node_is_leaf),
		.left_child    (left_child),
		.right_child   (right_child),
		.leaf_symbol   (leaf_symbol),
		.code_byte     (code_byte),
		.root_node     (root_q),
		.rd_idx        (rd_idx),
		.rd_node       (rd_node),
		.wr            (wr),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.symbol        (symbol),
		.end_of_message(end_of_message),
		.last          (last)
	);

endmodule

[hdl/htd_checker.sv]
`include "huffman_tree_decoder_macros.svh"

module htd_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        result_valid,
	input logic        result_ready,
	input logic [6:0]  symbol,
	input logic        end_of_message,
	input logic        last
);

	// A stalled result transfer holds
	`HTD_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(symbol) && $stable(end_of_message) && $stable(last))

	// End of message is flagged exactly on NUL
	`HTD_ASSERT_SAME(a_eom_nul, result_valid, end_of_message == (symbol == 7'd0))

	// NUL closes the byte's results
	`HTD_ASSERT_SAME(a_eom_last, result_valid && end_of_message, last)

	// A root write reads back on the next cycle
	`HTD_ASSERT_NEXT(a_root_wr, psel && penable && pwrite && !paddr[2], prdata[7:0] == $past(pwdata[7:0]))

endmodule

bind huffman_tree_decoder htd_port_checker u_htd_checker (.*);

[tb/htd_checker.sv]
module htd_checker import htd_pkg::*; #(
	parameter logic [2:0] ROOT_ADDR = 3'd0,
	parameter int MAX_PRINTED = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  node_index,
	input  logic        node_is_leaf,
	input  logic [7:0]  left_child,
	input  logic [7:0]  right_child,
	input  logic [6:0]  leaf_symbol,
	input  logic [7:0]  code_byte,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [6:0]  symbol,
	input  logic        end_of_message,
	input  logic        last,
	output int          fail_count,
	output int          syms_outstanding,
	output int          syms_checked,
	output int          eom_checked
);

	// one decoded symbol as it should leave the block
	typedef struct packed {
		sym_t sym;
		logic eom;
		logic last;
	} decoded_t;

	node_t    tree [0:(1<<IDX_W)-1];
	idx_t     root_idx;
	idx_t     walk_idx;
	logic     msg_ended;
	decoded_t expected_syms [$];
	int       errors;
	int       checked;
	int       eoms;

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// walk the tree for one code byte, MSB first, queue every symbol it yields
	task automatic walk_code_byte(input logic [7:0] code);
		logic [7:0] bits;
		node_t      cur;
		idx_t       nxt;
		logic       hit;
		sym_t       got [8];
		sym_t       s;
		int         n;
		bits = code;
		n = 0;
		for (int b = 0; b < 8 && !msg_ended; b++) begin
			cur = tree[walk_idx];
			hit = 1'b0;
			s = SYM_NUL;
			if (cur.leaf) begin
				// walk sits on a leaf (root is a leaf): every bit yields it
				hit = 1'b1;
				s = cur.sym;
			end else begin
				nxt = bits[7] ? cur.right : cur.left;
				if (tree[nxt].leaf) begin
					hit = 1'b1;
					s = tree[nxt].sym;
				end else begin
					walk_idx = nxt;
				end
			end
			if (hit) begin
				walk_idx = root_idx;
				got[n] = s;
				n++;
				// NUL ends the message, rest of the byte is dropped
				if (s == SYM_NUL)
					msg_ended = 1'b1;
			end
			bits = bits << 1;
		end
		for (int i = 0; i < n; i++)
			expected_syms.push_back('{sym: got[i], eom: (got[i] == SYM_NUL), last: (i == n - 1)});
	endtask

	task automatic check_symbol();
		decoded_t want;
		if (expected_syms.size() == 0) begin
			report_mismatch($sformatf("symbol %0d transfer with nothing expected", symbol));
			return;
		end
		want = expected_syms.pop_front();
		checked++;
		if (want.eom)
			eoms++;
		if (symbol !== want.sym)
			report_mismatch($sformatf("symbol got %0d want %0d", symbol, want.sym));
		if (end_of_message !== want.eom)
			report_mismatch($sformatf("end_of_message got %b want %b (symbol %0d)",
				end_of_message, want.eom, want.sym));
		if (last !== want.last)
			report_mismatch($sformatf("last got %b want %b (symbol %0d)",
				last, want.last, want.sym));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_syms.delete();
			root_idx = '0;
			walk_idx = '0;
			msg_ended = 1'b0;
			errors = 0;
			checked = 0;
			eoms = 0;
		end else begin
			// result transfers are matched before this edge's item adds anything
			if (result_valid && result_ready)
				check_symbol();

			// register port: track writes, check read data
			if (psel && penable && pready && paddr == ROOT_ADDR) begin
				if (pwrite)
					root_idx = pwdata[IDX_W-1:0];
				else if (prdata !== {{(32-IDX_W){1'b0}}, root_idx})
					report_mismatch($sformatf("root_node read got %0h want %0h",
						prdata, root_idx));
			end

			// item transfers
			if (item_valid && item_ready) begin
				case (opcode)
					OP_NODE_WRITE: begin
						tree[node_index].leaf = node_is_leaf;
						tree[node_index].left = left_child;
						tree[node_index].right = right_child;
						tree[node_index].sym = leaf_symbol;
					end
					OP_DECODE: walk_code_byte(code_byte);
					OP_RESTART: begin
						walk_idx = root_idx;
						msg_ended = 1'b0;
					end
					default: ;
				endcase
			end
		end
		fail_count <= errors;
		syms_outstanding <= expected_syms.size();
		syms_checked <= checked;
		eom_checked <= eoms;
	end

endmodule

[tb/tb_top.sv]
module tb_top import htd_pkg::*;;

	localparam logic [2:0] ROOT_ADDR    = 3'd0;
	localparam logic [1:0] OP_UNKNOWN   = 2'd3;
	localparam int         RANDOM_ITEMS = 410;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         CYCLE_LIMIT  = 1000000;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	typedef struct {
		logic [1:0] op;
		idx_t       idx;
		logic       leaf;
		idx_t       lft;
		idx_t       rgt;
		sym_t       sym;
		logic [7:0] code;
	} tree_item_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_ready;
	logic [1:0]  opcode;
	logic [7:0]  node_index;
	logic        node_is_leaf;
	logic [7:0]  left_child;
	logic [7:0]  right_child;
	logic [6:0]  leaf_symbol;
	logic [7:0]  code_byte;
	logic        result_valid;
	logic        result_ready;
	logic [6:0]  symbol;
	logic        end_of_message;
	logic        last;

	int fail_count;
	int syms_outstanding;
	int syms_checked;
	int eom_checked;

	int cycle_no = 0;

	// stimulus bookkeeping: nodes already written, so no walk ever reads an empty slot
	bit         node_known [0:(1<<IDX_W)-1];
	idx_t       known_list [$];
	tree_item_t plan [$];
	int         items_planned = 0;
	int         n_writes = 0;
	int         n_decodes = 0;
	int         n_restarts = 0;
	int         n_unknown = 0;
	int         n_roots = 0;

	rx_mode_t rx_mode;
	int       rx_left;

	huffman_tree_decoder u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.opcode         (opcode),
		.node_index     (node_index),
		.node_is_leaf   (node_is_leaf),
		.left_child     (left_child),
		.right_child    (right_child),
		.leaf_symbol    (leaf_symbol),
		.code_byte      (code_byte),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.symbol         (symbol),
		.end_of_message (end_of_message),
		.last           (last)
	);

	htd_checker #(
		.ROOT_ADDR (ROOT_ADDR)
	) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.opcode           (opcode),
		.node_index       (node_index),
		.node_is_leaf     (node_is_leaf),
		.left_child       (left_child),
		.right_child      (right_child),
		.leaf_symbol      (leaf_symbol),
		.code_byte        (code_byte),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.symbol           (symbol),
		.end_of_message   (end_of_message),
		.last             (last),
		.fail_count       (fail_count),
		.syms_outstanding (syms_outstanding),
		.syms_checked     (syms_checked),
		.eom_checked      (eom_checked)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d symbols still due", cycle_no, syms_outstanding);
			$display("Verification failed");
			$finish;
		end
	end

	// result side back-pressure: switch between stall styles every so often
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(40, 160);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   result_ready <= 1'b1;
			RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: result_ready <= ($urandom_range(0, 7) == 0);
			default:   result_ready <= ((cycle_no % 16) >= 11);
		endcase
	end

	function automatic sym_t pick_leaf_sym();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return SYM_NUL;
		if (r == 1)
			return 7'h7F;
		return sym_t'($urandom_range(1, 126));
	endfunction

	function automatic idx_t pick_known();
		return known_list[$urandom_range(0, known_list.size() - 1)];
	endfunction

	// all fields random, opcode as given
	function automatic tree_item_t random_item(input logic [1:0] op);
		tree_item_t it;
		it.op = op;
		it.idx = idx_t'($urandom_range(0, 255));
		it.leaf = 1'($urandom_range(0, 1));
		it.lft = idx_t'($urandom_range(0, 255));
		it.rgt = idx_t'($urandom_range(0, 255));
		it.sym = sym_t'($urandom_range(0, 127));
		it.code = 8'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic add_node(input idx_t i, input logic leaf, input idx_t l, input idx_t r,
			input sym_t s);
		tree_item_t it;
		it = random_item(OP_NODE_WRITE);
		it.idx = i;
		it.leaf = leaf;
		it.lft = l;
		it.rgt = r;
		it.sym = s;
		plan.push_back(it);
		if (!node_known[i]) begin
			node_known[i] = 1'b1;
			known_list.push_back(i);
		end
		items_planned++;
		n_writes++;
	endtask

	task automatic add_decode(input logic [7:0] c);
		tree_item_t it;
		it = random_item(OP_DECODE);
		it.code = c;
		plan.push_back(it);
		items_planned++;
		n_decodes++;
	endtask

	task automatic add_op(input logic [1:0] op);
		plan.push_back(random_item(op));
		items_planned++;
		if (op == OP_RESTART) begin
			n_restarts++;
		end else begin
			n_unknown++;
		end
	endtask

	// stray node write: leaves keep random children, internal nodes point at written nodes
	task automatic add_noise_node();
		if ($urandom_range(0, 1) == 1)
			add_node(idx_t'($urandom_range(0, 255)), 1'b1, idx_t'($urandom_range(0, 255)),
				idx_t'($urandom_range(0, 255)), pick_leaf_sym());
		else
			add_node(idx_t'($urandom_range(0, 255)), 1'b0, pick_known(), pick_known(),
				sym_t'($urandom_range(0, 127)));
	endtask

	// a proper code tree: random leaves merged pairwise, root placed at forced if >= 0
	task automatic plan_tree(input int forced, output idx_t top_idx);
		idx_t pool [$];
		idx_t a;
		idx_t b;
		idx_t p;
		int   i;
		repeat ($urandom_range(2, 8)) begin
			p = idx_t'($urandom_range(0, 255));
			add_node(p, 1'b1, idx_t'($urandom_range(0, 255)), idx_t'($urandom_range(0, 255)),
				pick_leaf_sym());
			pool.push_back(p);
		end
		while (pool.size() > 1) begin
			i = $urandom_range(0, pool.size() - 1);
			a = pool[i];
			pool.delete(i);
			i = $urandom_range(0, pool.size() - 1);
			b = pool[i];
			pool.delete(i);
			if (pool.size() == 0 && forced >= 0)
				p = idx_t'(forced);
			else
				p = idx_t'($urandom_range(0, 255));
			add_node(p, 1'b0, a, b, sym_t'($urandom_range(0, 127)));
			pool.push_back(p);
		end
		top_idx = pool[0];
	endtask

	// message traffic on the current tree: mostly code bytes
	task automatic plan_traffic(input int count);
		int r;
		add_op(OP_RESTART);
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				add_decode(8'($urandom_range(0, 255)));
			else if (r < 80)
				add_op(OP_RESTART);
			else if (r < 92)
				add_noise_node();
			else
				add_op(OP_UNKNOWN);
		end
	endtask

	// send the plan in bursts; valid is only dropped when a gap follows or the plan is done
	task automatic send_plan();
		tree_item_t it;
		int         burst;
		int         gap;
		int         r;
		while (plan.size() != 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && plan.size() != 0) begin
				it = plan.pop_front();
				opcode <= it.op;
				node_index <= it.idx;
				node_is_leaf <= it.leaf;
				left_child <= it.lft;
				right_child <= it.rgt;
				leaf_symbol <= it.sym;
				code_byte <= it.code;
				item_valid <= 1'b1;
				do @(posedge clk); while (!item_ready);
				burst--;
			end
			r = $urandom_range(0, 9);
			if (r < 4)
				gap = 0;
			else if (r < 7)
				gap = $urandom_range(1, 3);
			else if (r < 9)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(13, 40);
			if (gap > 0 || plan.size() == 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every symbol has been taken, then let a trailing byte finish
	task automatic wait_for_quiet();
		@(posedge clk);
		while (syms_outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ROOT_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// write root_node, then read it back
	task automatic set_root(input idx_t r);
		apb_access(1'b1, {{(32-IDX_W){1'b0}}, r});
		apb_access(1'b0, '0);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n_roots++;
	endtask

	initial begin
		idx_t next_root;
		int   base;
		int   phase;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ROOT_ADDR;
		pwdata = '0;
		item_valid = 1'b0;
		opcode = OP_NODE_WRITE;
		node_index = '0;
		node_is_leaf = 1'b0;
		left_child = '0;
		right_child = '0;
		leaf_symbol = '0;
		code_byte = '0;
		result_ready = 1'b0;
		rx_mode = RX_OPEN;
		rx_left = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: root 0 after reset; 0 -> {leaf 1, node 3}, 3 -> {leaf 2, NUL leaf 255}
		add_node(8'd1, 1'b1, 8'hFF, 8'h00, 7'h7F);
		add_node(8'd2, 1'b1, 8'h00, 8'hFF, 7'h01);
		add_node(8'd255, 1'b1, 8'h5A, 8'hA5, SYM_NUL);
		add_node(8'd3, 1'b0, 8'd2, 8'd255, 7'h7F);
		add_node(8'd0, 1'b0, 8'd1, 8'd3, 7'h00);
		add_decode(8'h00);   // eight symbols from one byte
		add_decode(8'hAA);   // two-level codes
		add_decode(8'h01);   // walk left mid-tree at byte end
		add_decode(8'h7F);   // code spans the byte boundary, then NUL drops the tail
		add_decode(8'h00);   // message over: nothing comes out
		add_op(OP_UNKNOWN);
		add_op(OP_RESTART);
		add_decode(8'hFF);   // NUL as the first symbol
		add_op(OP_RESTART);
		add_decode(8'h01);   // leave the walk on node 3
		send_plan();
		wait_for_quiet();

		// new root is a leaf; the walk still finishes its code from node 3 first
		set_root(8'd1);
		add_decode(8'h3F);
		add_op(OP_RESTART);
		add_decode(8'h00);
		send_plan();
		wait_for_quiet();

		// top root index, itself the NUL leaf
		set_root(8'd255);
		add_op(OP_RESTART);
		add_decode(8'h55);
		send_plan();
		wait_for_quiet();

		// random part: build a tree, point root at it, run messages over it
		base = items_planned;
		phase = 0;
		while (items_planned - base < RANDOM_ITEMS) begin
			plan_tree((phase == 0) ? 0 : ((phase == 1) ? 255 : -1), next_root);
			send_plan();
			wait_for_quiet();
			set_root(next_root);
			plan_traffic($urandom_range(30, 50));
			send_plan();
			wait_for_quiet();
			phase++;
		end

		$display("covered %0d node writes, %0d code bytes, %0d restarts, %0d unused opcodes, %0d root settings",
			n_writes, n_decodes, n_restarts, n_unknown, n_roots);
		$display("checked %0d decoded symbols, %0d of them end of message",
			syms_checked, eom_checked);
		if (fail_count == 0 && syms_outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
